FILE: rtl/bounded_sequential_list_unit_defines.svh
// Assertion macros used by the bounded sequential list top level.
`ifndef BOUNDED_SEQUENTIAL_LIST_UNIT_DEFINES_SVH
`define BOUNDED_SEQUENTIAL_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bounded sequential list: check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bounded sequential list: check failed");

`endif

FILE: rtl/bsl_pkg.sv
// Package with the widths, command codes and cell control type of the list unit.
package bsl_pkg;

	localparam int unsigned CMD_W        = 3;
	localparam int unsigned KEY_W        = 32;
	localparam int unsigned PAY_PORT_W   = 64;
	localparam int unsigned POS_W        = 8;
	localparam int unsigned CNT_PORT_W   = 8;
	localparam int unsigned BSL_DEPTH     = 128;
	localparam int unsigned BSL_PAYLOAD_W = 64;
	// Cells whose selected entries are merged in one registered group.
	localparam int unsigned GATHER_GROUP = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND    = 3'd0,
		CMD_PREPEND   = 3'd1,
		CMD_SORTED    = 3'd2,
		CMD_REM_LAST  = 3'd3,
		CMD_REM_FIRST = 3'd4,
		CMD_REM_KEY   = 3'd5,
		CMD_READ_POS  = 3'd6,
		CMD_FIND_KEY  = 3'd7
	} cmd_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		cmd_t cmd;
		logic cmp; // capture the compare flags
		logic ins; // insert: open the gap and write the new entry
		logic rem; // remove: close the gap from the hit onwards
		logic sel; // read or find: present the first hit cell
	} cell_ctrl_t;

endpackage

FILE: rtl/bsl_req_if.sv
// Request channel interface: command, key, payload and position.
interface bsl_req_if import bsl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       cmd;
	logic signed [KEY_W-1:0] entry_key;
	logic [PAY_PORT_W-1:0]  entry_payload;
	logic [POS_W-1:0]       position;

	modport source (output valid, cmd, entry_key, entry_payload, position, input ready);
	modport sink   (input valid, cmd, entry_key, entry_payload, position, output ready);
endinterface

FILE: rtl/bsl_rsp_if.sv
// Response channel interface: status, found entry, count and flags.
interface bsl_rsp_if import bsl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    ok;
	logic signed [KEY_W-1:0] found_key;
	logic [PAY_PORT_W-1:0]   found_payload;
	logic [CNT_PORT_W-1:0]   count;
	logic                    is_full;
	logic                    is_empty;

	modport source (output valid, ok, found_key, found_payload, count, is_full, is_empty,
		input ready);
	modport sink   (input valid, ok, found_key, found_payload, count, is_full, is_empty,
		output ready);
endinterface

FILE: rtl/bsl_cell.sv
// One list slot: stores an entry, compares it and shifts with its neighbours.
module bsl_cell import bsl_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = $clog2(BSL_DEPTH + 1),
	parameter int unsigned PW  = BSL_PAYLOAD_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctrl_t          ctrl,
	input  logic [CW-1:0]       count,
	input  logic [KEY_W-1:0]    key,
	input  logic [PW-1:0]       pay,
	input  logic [POS_W-1:0]    pos,
	input  logic                hit_in,
	output logic                hit_out,
	input  logic [KEY_W-1:0]    left_key,
	input  logic [PW-1:0]       left_pay,
	input  logic [KEY_W-1:0]    right_key,
	input  logic [PW-1:0]       right_pay,
	output logic [KEY_W-1:0]    key_q,
	output logic [PW-1:0]       pay_q,
	output logic [KEY_W-1:0]    sel_key,
	output logic [PW-1:0]       sel_pay
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam int unsigned   POS_C = IDX + 1;

	logic valid_q, lt_q, eq_q, pos_q;
	logic stop, first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
			pos_q   <= 1'b0;
		end else if (ctrl.cmp) begin
			valid_q <= count > IDX_C;
			lt_q    <= $signed(key_q) < $signed(key);
			eq_q    <= key_q == key;
			pos_q   <= (POS_C < 256) && (pos == POS_W'(POS_C));
		end
	end

	// The first cell that stops the scan marks where the command acts.
	always_comb begin
		case (ctrl.cmd)
			CMD_APPEND:    stop = !valid_q;
			CMD_PREPEND:   stop = 1'b1;
			CMD_SORTED:    stop = !(valid_q && lt_q);
			CMD_REM_LAST:  stop = 1'b0;
			CMD_REM_FIRST: stop = valid_q;
			CMD_REM_KEY:   stop = valid_q && eq_q;
			CMD_READ_POS:  stop = valid_q && pos_q;
			CMD_FIND_KEY:  stop = valid_q && eq_q;
			default:       stop = 1'b0;
		endcase
	end

	assign hit_out = hit_in | stop;
	assign first   = stop & ~hit_in & ctrl.sel;
	assign sel_key = first ? key_q : '0;
	assign sel_pay = first ? pay_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (hit_in) begin
				key_q <= left_key;
				pay_q <= left_pay;
			end else if (stop) begin
				key_q <= key;
				pay_q <= pay;
			end
		end else if (ctrl.rem && hit_out) begin
			key_q <= right_key;
			pay_q <= right_pay;
		end
	end

endmodule

FILE: rtl/bsl_gather.sv
// Registered OR tree that collects the one selected entry from the cell row.
module bsl_gather import bsl_pkg::*; #(
	parameter int unsigned DEPTH = BSL_DEPTH,
	parameter int unsigned PW    = BSL_PAYLOAD_W
) (
	input  logic             clk,
	input  logic             load,
	input  logic [KEY_W-1:0] sel_key [DEPTH],
	input  logic [PW-1:0]    sel_pay [DEPTH],
	output logic [KEY_W-1:0] key,
	output logic [PW-1:0]    pay
);

	localparam int unsigned NG = (DEPTH + GATHER_GROUP - 1) / GATHER_GROUP;

	logic [KEY_W-1:0] grp_key_d  [NG];
	logic [PW-1:0]    grp_pay_d  [NG];
	logic [KEY_W-1:0] grp_key_s2 [NG];
	logic [PW-1:0]    grp_pay_s2 [NG];

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_key_d[g] = '0;
			grp_pay_d[g] = '0;
			for (int j = 0; j < GATHER_GROUP; j++) begin
				if (g * GATHER_GROUP + j < DEPTH) begin
					grp_key_d[g] = grp_key_d[g] | sel_key[g * GATHER_GROUP + j];
					grp_pay_d[g] = grp_pay_d[g] | sel_pay[g * GATHER_GROUP + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int g = 0; g < NG; g++) begin
				grp_key_s2[g] <= grp_key_d[g];
				grp_pay_s2[g] <= grp_pay_d[g];
			end
		end
	end

	always_comb begin
		key = '0;
		pay = '0;
		for (int g = 0; g < NG; g++) begin
			key = key | grp_key_s2[g];
			pay = pay | grp_pay_s2[g];
		end
	end

endmodule

FILE: rtl/bounded_sequential_list_unit.sv
// Top level of the bounded sequential list: sequencer, cell row and result gather.
//
// The unit keeps a packed list of up to DEPTH entries (signed 32-bit key plus a
// PAYLOAD_WIDTH-bit payload) in a row of cells, entry n in cell n. A command arrives
// as one transfer on the req channel and yields exactly one transfer on the rsp
// channel carrying ok, the entry read or found, the new count and the full and empty
// flags. Inserts move every later entry one cell up and removals one cell down, each
// cell loading from its neighbour.
// Sequence: after the request transfer the unit first captures the per-cell compare
// flags (ST_CMP), then resolves the first hit along the cell chain while the cells
// shift and the selected entry enters the gather registers (ST_UPD), and then
// merges the gather groups into the rsp register (ST_GATH). The unit takes no new
// request until this compare, shift and gather sequence is through.
// req.ready is high only while the sequencer is idle; a response still waiting for
// rsp.ready does not block the next request, but its result is held in the
// gather cycle until the rsp register is free.
// Reset (arst_n low) empties the list at once; the cell contents are left undefined
// and need no clearing pass, since only cells below the count are ever read.
module bounded_sequential_list_unit import bsl_pkg::*; #(
	parameter int unsigned DEPTH         = BSL_DEPTH,
	parameter int unsigned PAYLOAD_WIDTH = BSL_PAYLOAD_W
) (
	input  logic         clk,
	input  logic         arst_n,
	bsl_req_if.sink      req,
	bsl_rsp_if.source    rsp
);

`include "bounded_sequential_list_unit_defines.svh"

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_GATH = 4'b1000
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic [KEY_W-1:0]         key_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic [POS_W-1:0]         pos_q;
	logic [CW-1:0]            count_q;
	logic                     ok_q;
	logic                     rsp_valid_q;

	cell_ctrl_t               ctrl;
	logic                     full, empty, is_ins, is_rem, is_sel, stall;
	logic [DEPTH:0]           hit;
	logic [KEY_W-1:0]         cell_key [DEPTH];
	logic [PAYLOAD_WIDTH-1:0] cell_pay [DEPTH];
	logic [KEY_W-1:0]         sel_key  [DEPTH];
	logic [PAYLOAD_WIDTH-1:0] sel_pay  [DEPTH];
	logic [KEY_W-1:0]         gath_key;
	logic [PAYLOAD_WIDTH-1:0] gath_pay;

	assign full  = count_q == FULL_C;
	assign empty = count_q == '0;

	assign is_ins = (cmd_q == CMD_APPEND) || (cmd_q == CMD_PREPEND) || (cmd_q == CMD_SORTED);
	assign is_rem = (cmd_q == CMD_REM_FIRST) || (cmd_q == CMD_REM_KEY);
	assign is_sel = (cmd_q == CMD_READ_POS) || (cmd_q == CMD_FIND_KEY);

	// The hit chain is a running OR of each cell's stop condition, so hit[DEPTH]
	// says whether any cell matched at all.
	assign hit[0] = 1'b0;

	always_comb begin
		ctrl.cmd = cmd_q;
		ctrl.cmp = state_q == ST_CMP;
		ctrl.ins = (state_q == ST_UPD) && is_ins && !full;
		ctrl.rem = (state_q == ST_UPD) && is_rem && hit[DEPTH];
		ctrl.sel = is_sel;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0]         lk, rk;
		logic [PAYLOAD_WIDTH-1:0] lp, rp;

		// The first cell takes the new entry rather than a left neighbour, and the
		// last cell keeps its own contents when the row closes up.
		if (i == 0) begin : g_left_end
			assign lk = key_q;
			assign lp = pay_q;
		end else begin : g_left
			assign lk = cell_key[i-1];
			assign lp = cell_pay[i-1];
		end
		if (i == DEPTH - 1) begin : g_right_end
			assign rk = cell_key[i];
			assign rp = cell_pay[i];
		end else begin : g_right
			assign rk = cell_key[i+1];
			assign rp = cell_pay[i+1];
		end

		bsl_cell #(
			.IDX (i),
			.CW  (CW),
			.PW  (PAYLOAD_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.count     (count_q),
			.key       (key_q),
			.pay       (pay_q),
			.pos       (pos_q),
			.hit_in    (hit[i]),
			.hit_out   (hit[i+1]),
			.left_key  (lk),
			.left_pay  (lp),
			.right_key (rk),
			.right_pay (rp),
			.key_q     (cell_key[i]),
			.pay_q     (cell_pay[i]),
			.sel_key   (sel_key[i]),
			.sel_pay   (sel_pay[i])
		);
	end

	bsl_gather #(
		.DEPTH (DEPTH),
		.PW    (PAYLOAD_WIDTH)
	) u_gather (
		.clk     (clk),
		.load    (state_q == ST_UPD),
		.sel_key (sel_key),
		.sel_pay (sel_pay),
		.key     (gath_key),
		.pay     (gath_pay)
	);

	assign req.ready = state_q == ST_IDLE;
	assign stall     = rsp_valid_q && !rsp.ready;

	// Request capture; the payload is cut to the stored width here.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= cmd_t'(req.cmd);
			key_q <= req.entry_key;
			pay_q <= PAYLOAD_WIDTH'(req.entry_payload);
			pos_q <= req.position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_GATH;
					if (is_ins) begin
						ok_q <= !full;
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end else if (cmd_q == CMD_REM_LAST) begin
						ok_q <= !empty;
						if (!empty) begin
							count_q <= count_q - 1'b1;
						end
					end else begin
						ok_q <= hit[DEPTH];
						if (is_rem && hit[DEPTH]) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				ST_GATH: begin
					if (!stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response register: loaded once the gather is merged and the last
	// response has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_GATH && !stall) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GATH && !stall) begin
			rsp.ok            <= ok_q;
			rsp.found_key     <= gath_key;
			rsp.found_payload <= PAY_PORT_W'(gath_pay);
			rsp.count         <= CNT_PORT_W'(count_q);
			rsp.is_full       <= full;
			rsp.is_empty      <= empty;
		end
	end

	assign rsp.valid = rsp_valid_q;

	// The count never goes past the capacity of the row.
	`BSL_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_C)

	// One command moves the count by at most one entry.
	`BSL_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))

	// A request transfer always starts the compare cycle.
	`BSL_ASSERT_NEXT(a_req_starts, clk, arst_n, req.valid && req.ready, state_q == ST_CMP)

	// A free gather cycle always produces a response.
	`BSL_ASSERT_NEXT(a_rsp_made, clk, arst_n, state_q == ST_GATH && !stall, rsp_valid_q && state_q == ST_IDLE)

endmodule
